>>> rtl/tlt_pkg.sv
`timescale 1ns / 1ps
package tlt_pkg;

  // field widths of one entry
  localparam int VPN_W   = 22;   // vpn bits 31:10
  localparam int ASID_W  = 8;
  localparam int PPN_W   = 19;   // ppn bits 28:10
  localparam int FLG_W   = 9;
  localparam int EXT_W   = 4;
  localparam int CNT_W   = 6;    // replace counter
  localparam int LRU_W   = 6;
  localparam int INSTR_N = 4;    // instruction TLB entries
  localparam int DEF_UNIFIED = 64;

  // port widths
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // flag bit positions
  localparam int FB_VALID = 8;
  localparam int FB_SZ_HI = 7;
  localparam int FB_USER  = 6;
  localparam int FB_WRITE = 5;
  localparam int FB_SZ_LO = 4;
  localparam int FB_DIRTY = 2;
  localparam int FB_SHARE = 1;

  // flags kept on an instruction TLB entry
  localparam logic [FLG_W-1:0] ITLB_FLAG_MASK = 9'h1DA;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XLAT_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SV_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_BLOCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 3'd4;

  // request codes
  typedef enum logic [3:0] {
    FN_READ     = 4'd0,
    FN_WRITE    = 4'd1,
    FN_FETCH    = 4'd2,
    FN_LOAD     = 4'd3,
    FN_IADDR_WR = 4'd4,
    FN_IDATA_WR = 4'd5,
    FN_UADDR_WR = 4'd6,
    FN_UDATA_WR = 4'd7,
    FN_IADDR_RD = 4'd8,
    FN_IDATA_RD = 4'd9,
    FN_UADDR_RD = 4'd10,
    FN_UDATA_RD = 4'd11,
    FN_INVAL    = 4'd12
  } func_t;

  // result status codes
  localparam logic [3:0] STS_OK      = 4'd0;
  localparam logic [3:0] STS_AERR_R  = 4'd1;
  localparam logic [3:0] STS_AERR_W  = 4'd2;
  localparam logic [3:0] STS_MISS_R  = 4'd3;
  localparam logic [3:0] STS_MISS_W  = 4'd4;
  localparam logic [3:0] STS_INIT_WR = 4'd5;
  localparam logic [3:0] STS_PROT_R  = 4'd6;
  localparam logic [3:0] STS_PROT_W  = 4'd7;
  localparam logic [3:0] STS_MULTI   = 4'd8;

  typedef struct packed {
    logic [VPN_W-1:0]  vpn;
    logic [ASID_W-1:0] asid;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
    logic [EXT_W-1:0]  extra;
  } utlb_ent_t;

  typedef struct packed {
    logic [VPN_W-1:0]  vpn;
    logic [ASID_W-1:0] asid;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
  } itlb_ent_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_ENC  = 2'd2,
    S_EXEC = 2'd3
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture request
    logic cmp;     // register match vectors
    logic enc;     // register hit index and selected entries
    logic commit;  // update state and output register
  } dp_cmd_t;

endpackage

>>> rtl/tlt_ctrl.sv
`timescale 1ns / 1ps
module tlt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output tlt_pkg::dp_cmd_t cmd
);
  import tlt_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_CMP;
      S_CMP:   state_next = S_ENC;
      S_ENC:   state_next = S_EXEC;
      S_EXEC:  if (!out_full || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      S_CMP:   cmd.cmp = 1'b1;
      S_ENC:   cmd.enc = 1'b1;
      S_EXEC:  cmd.commit = !out_full || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_full <= 1'b1;
      else if (m_axis_tready) out_full <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_full;

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_full || m_axis_tready)) else $error("commit into full slot");
  a_cmp_to_enc: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (state == S_ENC)) else $error("compare stage skipped");
  a_load_to_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_CMP)) else $error("accepted request not started");

endmodule

>>> rtl/tlt_dp.sv
`timescale 1ns / 1ps
module tlt_dp #(
  parameter int UNIFIED_ENTRIES = tlt_pkg::DEF_UNIFIED
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tlt_pkg::dp_cmd_t                 cmd,
  input  logic                             cfg_wr_en,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tlt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [tlt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic [tlt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [tlt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import tlt_pkg::*;

  localparam int N  = UNIFIED_ENTRIES;
  localparam int UW = (N > 1) ? $clog2(N) : 1;
  localparam logic [CNT_W:0] N_LIM = (CNT_W+1)'(N);

  // page mask from the size bits
  function automatic logic [31:0] size_mask(input logic [FLG_W-1:0] f);
    logic [31:0] m;
    case ({f[FB_SZ_HI], f[FB_SZ_LO]})
      2'b00:   m = 32'hFFFFFC00;
      2'b01:   m = 32'hFFFFF000;
      2'b10:   m = 32'hFFFF0000;
      default: m = 32'hFFF00000;
    endcase
    return m;
  endfunction

  function automatic logic ent_match(input logic [VPN_W-1:0] vpn, input logic [ASID_W-1:0] asid,
                                     input logic [FLG_W-1:0] f, input logic [31:0] key,
                                     input logic asid_chk, input logic need_valid,
                                     input logic [ASID_W-1:0] cur);
    logic ok;
    ok = (((({vpn, 10'b0}) ^ key) & size_mask(f)) == 32'd0);
    if (need_valid && !f[FB_VALID]) ok = 1'b0;
    if (asid_chk && !f[FB_SHARE] && (asid != cur)) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [31:0] phys_of(input logic [PPN_W-1:0] ppn,
                                          input logic [FLG_W-1:0] f, input logic [31:0] va);
    logic [31:0] m;
    m = size_mask(f);
    return ({3'b0, ppn, 10'b0} & m) | (va & ~m);
  endfunction

  function automatic logic [LRU_W-1:0] lru_touch(input logic [LRU_W-1:0] l,
                                                 input logic [1:0] k);
    logic [LRU_W-1:0] r;
    case (k)
      2'd0:    r = l & 6'h07;
      2'd1:    r = (l & 6'h19) | 6'h20;
      2'd2:    r = (l & 6'h3E) | 6'h14;
      default: r = l | 6'h0B;
    endcase
    return r;
  endfunction

  // configuration
  logic              cfg_at, cfg_sv, cfg_sq;
  logic [ASID_W-1:0] cfg_asid;
  logic [CNT_W-1:0]  cfg_urb;

  // request
  logic [3:0]       in_func;
  logic             in_priv;
  logic [31:0]      in_addr, in_wd, in_lo;
  logic [EXT_W-1:0] in_ab;

  // arrays and replacement state
  utlb_ent_t        utlb [N];
  itlb_ent_t        itlb [INSTR_N];
  logic [CNT_W-1:0] urc;
  logic [LRU_W-1:0] lru;

  // stage registers
  logic [N-1:0]       u_match;
  logic [INSTR_N-1:0] i_match;
  logic               u_any, u_multi, i_any, i_multi;
  logic [UW-1:0]      u_idx;
  logic [1:0]         i_idx;
  utlb_ent_t          uh, ua;
  itlb_ent_t          ih;

  // output register
  logic [31:0] out_pa, out_rd;
  logic [3:0]  out_st;

  // compare stage
  logic               assoc, asid_chk;
  logic [31:0]        key;
  logic [N-1:0]       u_match_c;
  logic [INSTR_N-1:0] i_match_c;

  always_comb begin
    assoc    = (in_func == FN_UADDR_WR);
    key      = assoc ? in_wd : in_addr;
    asid_chk = assoc || !cfg_sv || !in_priv;
    for (int i = 0; i < N; i++) begin
      u_match_c[i] = ent_match(utlb[i].vpn, utlb[i].asid, utlb[i].flags, key,
                               asid_chk, !assoc, cfg_asid);
    end
    for (int i = 0; i < INSTR_N; i++) begin
      i_match_c[i] = ent_match(itlb[i].vpn, itlb[i].asid, itlb[i].flags, in_addr,
                               asid_chk, 1'b1, cfg_asid);
    end
  end

  // encode stage
  logic [UW-1:0] u_idx_c;
  logic [1:0]    i_idx_c;
  logic [5:0]    ui;
  logic          ui_ok;

  assign ui    = in_addr[13:8];
  assign ui_ok = ({1'b0, ui} < N_LIM);

  always_comb begin
    u_idx_c = '0;
    i_idx_c = '0;
    for (int i = 0; i < N; i++) if (u_match[i]) u_idx_c = UW'(i);
    for (int i = 0; i < INSTR_N; i++) if (i_match[i]) i_idx_c = 2'(i);
  end

  // execute stage
  itlb_ent_t        ia;
  logic [31:0]      res_pa, res_rd;
  logic [3:0]       res_st;
  logic             step, refill, touch;
  logic [1:0]       touch_k, victim;
  logic [CNT_W:0]   urc_sum;
  logic [CNT_W-1:0] urc_next;

  assign ia = itlb[in_addr[8:7]];

  always_comb begin
    if ((lru & 6'h38) == 6'h38)      victim = 2'd0;
    else if ((lru & 6'h26) == 6'h06) victim = 2'd1;
    else if ((lru & 6'h15) == 6'h01) victim = 2'd2;
    else                             victim = 2'd3;
    urc_sum  = {1'b0, urc} + 7'd1;
    urc_next = ((urc_sum == {1'b0, cfg_urb}) || (urc_sum >= N_LIM)) ? '0 : urc_sum[CNT_W-1:0];
  end

  always_comb begin
    logic is_f, is_w, go_tlb;
    is_f    = (in_func == FN_FETCH);
    is_w    = (in_func == FN_WRITE);
    go_tlb  = 1'b0;
    res_pa  = '0;
    res_st  = STS_OK;
    res_rd  = '0;
    step    = 1'b0;
    refill  = 1'b0;
    touch   = 1'b0;
    touch_k = '0;
    unique case (in_func)
      FN_READ, FN_WRITE, FN_FETCH: begin
        // fixed regions
        if (in_addr[31]) begin
          if (is_f) begin
            if (!in_priv || in_addr >= 32'hE0000000) res_st = STS_AERR_R;
            else if (in_addr < 32'hC0000000) res_pa = in_addr;
            else go_tlb = 1'b1;
          end else if (in_priv) begin
            if (in_addr < 32'hC0000000 || in_addr >= 32'hE0000000) res_pa = in_addr;
            else go_tlb = 1'b1;
          end else if (in_addr >= 32'hE0000000 && in_addr < 32'hE4000000 && !cfg_sq) begin
            res_pa = in_addr;
          end else begin
            res_st = is_w ? STS_AERR_W : STS_AERR_R;
          end
        end else begin
          go_tlb = 1'b1;
        end
        // table lookup
        if (go_tlb) begin
          if (!cfg_at) begin
            res_pa = in_addr;
          end else if (is_f) begin
            if (i_multi) begin
              res_st = STS_MULTI;
            end else if (i_any) begin
              touch   = 1'b1;
              touch_k = i_idx;
              if (!ih.flags[FB_USER] && !in_priv) res_st = STS_PROT_R;
              else res_pa = phys_of(ih.ppn, ih.flags, in_addr);
            end else begin
              step = 1'b1;
              if (!u_any) res_st = STS_MISS_R;
              else if (u_multi) res_st = STS_MULTI;
              else begin
                refill  = 1'b1;
                touch   = 1'b1;
                touch_k = victim;
                if (!uh.flags[FB_USER] && !in_priv) res_st = STS_PROT_R;
                else res_pa = phys_of(uh.ppn, uh.flags, in_addr);
              end
            end
          end else begin
            step = 1'b1;
            if (!u_any) res_st = is_w ? STS_MISS_W : STS_MISS_R;
            else if (u_multi) res_st = STS_MULTI;
            else if (is_w) begin
              if (in_priv ? !uh.flags[FB_WRITE]
                          : !(uh.flags[FB_WRITE] && uh.flags[FB_USER])) res_st = STS_PROT_W;
              else if (!uh.flags[FB_DIRTY]) res_st = STS_INIT_WR;
              else res_pa = phys_of(uh.ppn, uh.flags, in_addr);
            end else begin
              if (!uh.flags[FB_USER] && !in_priv) res_st = STS_PROT_R;
              else res_pa = phys_of(uh.ppn, uh.flags, in_addr);
            end
          end
        end
      end
      FN_UADDR_WR: if (in_addr[7] && u_multi) res_st = STS_MULTI;
      FN_IADDR_RD: res_rd = {ia.vpn, 1'b0, ia.flags[FB_VALID], ia.asid};
      FN_IDATA_RD: res_rd = {3'b0, ia.ppn, 1'b0, ia.flags};
      FN_UADDR_RD: if (ui_ok) res_rd = {ua.vpn, ua.flags[FB_DIRTY], ua.flags[FB_VALID], ua.asid};
      FN_UDATA_RD: begin
        if (ui_ok) res_rd = in_addr[23] ? {28'b0, ua.extra} : {3'b0, ua.ppn, 1'b0, ua.flags};
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_at   <= 1'b0;
      cfg_sv   <= 1'b0;
      cfg_sq   <= 1'b0;
      cfg_asid <= '0;
      cfg_urb  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_XLAT_EN:  cfg_at   <= cfg_data[0];
        CFG_SV_MODE:  cfg_sv   <= cfg_data[0];
        CFG_SQ_BLOCK: cfg_sq   <= cfg_data[0];
        CFG_ASID:     cfg_asid <= cfg_data;
        CFG_BOUNDARY: cfg_urb  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_func <= s_axis_tuser[3:0];
      in_priv <= s_axis_tuser[4];
      in_addr <= s_axis_tdata[31:0];
      in_wd   <= s_axis_tdata[63:32];
      in_lo   <= s_axis_tdata[95:64];
      in_ab   <= s_axis_tdata[99:96];
    end
    if (cmd.cmp) begin
      u_match <= u_match_c;
      i_match <= i_match_c;
    end
    if (cmd.enc) begin
      u_any   <= |u_match;
      u_multi <= |(u_match & (u_match - {{(N-1){1'b0}}, 1'b1}));
      i_any   <= |i_match;
      i_multi <= |(i_match & (i_match - 4'd1));
      u_idx   <= u_idx_c;
      i_idx   <= i_idx_c;
      uh      <= utlb[u_idx_c];
      ih      <= itlb[i_idx_c];
      ua      <= utlb[ui[UW-1:0]];
    end
    if (cmd.commit) begin
      out_pa <= res_pa;
      out_st <= res_st;
      out_rd <= res_rd;
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) utlb[i] <= '0;
      for (int i = 0; i < INSTR_N; i++) itlb[i] <= '0;
      urc <= '0;
      lru <= '0;
    end else if (cmd.commit) begin
      if (step) urc <= urc_next;
      if (touch) lru <= lru_touch(lru, touch_k);
      unique case (in_func)
        FN_FETCH: begin
          if (refill) itlb[victim] <= '{vpn: uh.vpn, asid: uh.asid, ppn: uh.ppn,
                                        flags: uh.flags & ITLB_FLAG_MASK};
        end
        FN_LOAD: begin
          if ({1'b0, urc} < N_LIM) begin
            utlb[urc[UW-1:0]] <= '{vpn: in_wd[31:10], asid: in_wd[7:0], ppn: in_lo[28:10],
                                   flags: in_lo[8:0], extra: in_ab};
          end
        end
        FN_IADDR_WR: begin
          itlb[in_addr[8:7]].vpn             <= in_wd[31:10];
          itlb[in_addr[8:7]].asid            <= in_wd[7:0];
          itlb[in_addr[8:7]].flags[FB_VALID] <= in_wd[8];
        end
        FN_IDATA_WR: begin
          itlb[in_addr[8:7]].ppn   <= in_wd[28:10];
          itlb[in_addr[8:7]].flags <= in_wd[8:0] & ITLB_FLAG_MASK;
        end
        FN_UADDR_WR: begin
          if (in_addr[7]) begin
            // associative write: only a single match updates
            if (u_any && !u_multi) begin
              utlb[u_idx].flags[FB_VALID] <= in_wd[8];
              utlb[u_idx].flags[FB_DIRTY] <= in_wd[9];
            end
          end else if (ui_ok) begin
            utlb[ui[UW-1:0]].vpn             <= in_wd[31:10];
            utlb[ui[UW-1:0]].asid            <= in_wd[7:0];
            utlb[ui[UW-1:0]].flags[FB_VALID] <= in_wd[8];
            utlb[ui[UW-1:0]].flags[FB_DIRTY] <= in_wd[9];
          end
        end
        FN_UDATA_WR: begin
          if (ui_ok) begin
            if (in_addr[23]) begin
              utlb[ui[UW-1:0]].extra <= in_wd[3:0];
            end else begin
              utlb[ui[UW-1:0]].ppn   <= in_wd[28:10];
              utlb[ui[UW-1:0]].flags <= in_wd[8:0];
            end
          end
        end
        FN_INVAL: begin
          for (int i = 0; i < N; i++) utlb[i].flags[FB_VALID] <= 1'b0;
          for (int i = 0; i < INSTR_N; i++) itlb[i].flags[FB_VALID] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {out_rd, out_pa};
  assign m_axis_tuser = out_st;

  a_urc_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, urc} < N_LIM)) else $error("replace counter out of range");
  a_fetch_refill: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && refill) |-> (in_func == FN_FETCH && u_any && !u_multi))
    else $error("refill without single unified hit");

endmodule

>>> rtl/two_level_tlb_address_translator_core.sv
`timescale 1ns / 1ps
// Two-level TLB address translator.
// Input stream (s_axis): one request per transaction; tuser carries the
// request code and the privileged flag, tdata the address, write word,
// entry low word and assist bits. Output stream (m_axis): exactly one
// result per request; tdata carries the physical address and array read
// word, tuser the status code.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per clock;
// write only while no request is in flight.
// One request is in flight at a time: the controller steps each request
// through the compare, encode and execute states before accepting the next;
// the unified lookup is a parallel compare over all entries, registered,
// then encoded.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the execute step until the
// register frees up, with no state change before then.
// Reset (rst, synchronous) clears all entries, the replace counter, the
// pseudo-LRU bits and the configuration registers; no clearing pass needed.
module two_level_tlb_address_translator_core #(
  parameter int UNIFIED_ENTRIES = tlt_pkg::DEF_UNIFIED
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // address[31:0], write_data[63:32], entry_low_word[95:64], assist_bits[99:96], zero pad
  input  logic [tlt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func[3:0], privileged[4]
  input  logic [tlt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // phys_addr[31:0], read_data[63:32]
  output logic [tlt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status[3:0]
  output logic [tlt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  logic                             cfg_wr_en,
  input  logic [tlt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tlt_pkg::*;

  dp_cmd_t cmd;

  tlt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  tlt_dp #(
    .UNIFIED_ENTRIES (UNIFIED_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

>>> tb/two_level_tlb_address_translator_core_test.sv
`timescale 1ns / 1ps
module two_level_tlb_address_translator_core_test;
  import tlt_pkg::*;

  localparam int N_UNI = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [3:0] FN_SPARE = 4'd13;  // first unused request code

  // one expected or observed result
  typedef struct {
    logic [31:0] pa;
    logic [3:0]  st;
    logic [31:0] rd;
  } xlat_res_t;

  // queue of pending translation results and the comparison against them
  class xlat_scoreboard;
    xlat_res_t pending[$];
    int errors;
    int checked;

    function void note_request(xlat_res_t r);
      pending.push_back(r);
    endfunction

    function void check_result(xlat_res_t got);
      xlat_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pa=%h st=%0d rd=%h", got.pa, got.st, got.rd);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pa !== want.pa || got.st !== want.st || got.rd !== want.rd) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp pa=%h st=%0d rd=%h, got pa=%h st=%0d rd=%h",
                   checked, want.pa, want.st, want.rd, got.pa, got.st, got.rd);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  two_level_tlb_address_translator_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  xlat_scoreboard sb = new();

  // ---------------- translation predictor ----------------
  typedef struct {
    logic [31:0] vpn;
    logic [7:0]  asid;
    logic [31:0] ppn;
    logic [8:0]  flags;
    logic [3:0]  extra;
  } tlb_line_t;

  tlb_line_t uni[N_UNI];
  tlb_line_t ins[INSTR_N];
  logic [6:0] repl_ctr;
  logic [5:0] plru;
  logic xlat_on, sv_mode, sq_block;
  logic [7:0] cur_asid;
  logic [5:0] repl_bound;

  function automatic logic [31:0] page_mask(logic [8:0] f);
    case ({f[FB_SZ_HI], f[FB_SZ_LO]})
      2'b00: return 32'hFFFFFC00;
      2'b01: return 32'hFFFFF000;
      2'b10: return 32'hFFFF0000;
      default: return 32'hFFF00000;
    endcase
  endfunction

  function automatic bit line_hits(tlb_line_t e, logic [31:0] va, bit asid_chk, bit need_valid);
    if (need_valid && !e.flags[FB_VALID]) return 0;
    if (asid_chk && !e.flags[FB_SHARE] && e.asid != cur_asid) return 0;
    return ((e.vpn ^ va) & page_mask(e.flags)) == 0;
  endfunction

  // index of the single hit, -1 none, -2 several
  function automatic int scan_unified(logic [31:0] va, bit asid_chk, bit need_valid);
    int hit;
    hit = -1;
    for (int i = 0; i < N_UNI; i++)
      if (line_hits(uni[i], va, asid_chk, need_valid)) begin
        if (hit != -1) return -2;
        hit = i;
      end
    return hit;
  endfunction

  function automatic int unified_lookup(logic [31:0] va, bit asid_chk);
    repl_ctr = (repl_ctr + 7'd1) & 7'h7F;
    if (repl_ctr == {1'b0, repl_bound} || repl_ctr >= N_UNI) repl_ctr = 0;
    return scan_unified(va, asid_chk, 1);
  endfunction

  function automatic void plru_touch(int k);
    case (k)
      0: plru = plru & 6'h07;
      1: plru = (plru & 6'h19) | 6'h20;
      2: plru = (plru & 6'h3E) | 6'h14;
      default: plru = plru | 6'h0B;
    endcase
  endfunction

  function automatic int instr_lookup(logic [31:0] va, bit asid_chk);
    int hit;
    hit = -1;
    for (int i = 0; i < INSTR_N; i++)
      if (line_hits(ins[i], va, asid_chk, 1)) begin
        if (hit != -1) return -2;
        hit = i;
      end
    if (hit >= 0) plru_touch(hit);
    return hit;
  endfunction

  function automatic int instr_refill(int u);
    int k;
    if ((plru & 6'h38) == 6'h38) k = 0;
    else if ((plru & 6'h26) == 6'h06) k = 1;
    else if ((plru & 6'h15) == 6'h01) k = 2;
    else k = 3;
    plru_touch(k);
    ins[k] = uni[u];
    ins[k].flags = uni[u].flags & ITLB_FLAG_MASK;
    ins[k].extra = 0;
    return k;
  endfunction

  function automatic logic [31:0] phys_from(tlb_line_t e, logic [31:0] va);
    logic [31:0] m;
    m = page_mask(e.flags);
    return (e.ppn & m) | (va & ~m);
  endfunction

  function automatic void translate_va(logic [3:0] kind, bit priv, logic [31:0] va,
                                       output logic [31:0] pa, output logic [3:0] st);
    bit asid_chk;
    int n;
    logic [8:0] f;
    logic [3:0] aerr;
    aerr = (kind == FN_WRITE) ? STS_AERR_W : STS_AERR_R;
    pa = 0;
    st = STS_OK;
    if (va[31]) begin
      if (kind == FN_FETCH) begin
        if (!priv || va >= 32'hE0000000) begin st = STS_AERR_R; return; end
        if (va < 32'hC0000000) begin pa = va; return; end
      end else if (priv) begin
        if (va < 32'hC0000000 || va >= 32'hE0000000) begin pa = va; return; end
      end else begin
        if (va >= 32'hE0000000 && va < 32'hE4000000 && !sq_block) begin pa = va; return; end
        st = aerr;
        return;
      end
    end
    if (!xlat_on) begin pa = va; return; end
    asid_chk = !sv_mode || !priv;
    if (kind == FN_FETCH) begin
      n = instr_lookup(va, asid_chk);
      if (n == -1) begin
        n = unified_lookup(va, asid_chk);
        if (n >= 0) n = instr_refill(n);
      end
      if (n == -1) st = STS_MISS_R;
      else if (n == -2) st = STS_MULTI;
      else if (!ins[n].flags[FB_USER] && !priv) st = STS_PROT_R;
      else pa = phys_from(ins[n], va);
      return;
    end
    n = unified_lookup(va, asid_chk);
    if (n == -1) begin st = (kind == FN_WRITE) ? STS_MISS_W : STS_MISS_R; return; end
    if (n == -2) begin st = STS_MULTI; return; end
    f = uni[n].flags;
    if (kind == FN_WRITE) begin
      if (priv ? !f[FB_WRITE] : !(f[FB_WRITE] && f[FB_USER])) begin st = STS_PROT_W; return; end
      if (!f[FB_DIRTY]) begin st = STS_INIT_WR; return; end
    end else if (!f[FB_USER] && !priv) begin
      st = STS_PROT_R;
      return;
    end
    pa = phys_from(uni[n], va);
  endfunction

  // full effect of one request on the predictor, and its result
  function automatic xlat_res_t predict_request(logic [3:0] fn, bit priv, logic [31:0] a,
                                                logic [31:0] wd, logic [31:0] lo,
                                                logic [3:0] ab);
    xlat_res_t r;
    int ii, ui, tgt;
    r.pa = 0; r.st = STS_OK; r.rd = 0;
    ii = a[8:7];
    ui = a[13:8];
    case (fn)
      FN_READ, FN_WRITE, FN_FETCH: translate_va(fn, priv, a, r.pa, r.st);
      FN_LOAD:
        if (repl_ctr < N_UNI) begin
          uni[repl_ctr].vpn = wd & 32'hFFFFFC00;
          uni[repl_ctr].asid = wd[7:0];
          uni[repl_ctr].ppn = lo & 32'h1FFFFC00;
          uni[repl_ctr].flags = lo[8:0];
          uni[repl_ctr].extra = ab;
        end
      FN_IADDR_WR: begin
        ins[ii].vpn = wd & 32'hFFFFFC00;
        ins[ii].asid = wd[7:0];
        ins[ii].flags[FB_VALID] = wd[FB_VALID];
      end
      FN_IDATA_WR: begin
        ins[ii].ppn = wd & 32'h1FFFFC00;
        ins[ii].flags = wd[8:0] & ITLB_FLAG_MASK;
      end
      FN_UADDR_WR: begin
        if (a[7]) begin
          tgt = scan_unified(wd, 1, 0);
          if (tgt == -2) begin r.st = STS_MULTI; tgt = -1; end
        end else begin
          tgt = ui;
          uni[ui].vpn = wd & 32'hFFFFFC00;
          uni[ui].asid = wd[7:0];
        end
        if (tgt >= 0) begin
          uni[tgt].flags[FB_VALID] = wd[8];
          uni[tgt].flags[FB_DIRTY] = wd[9];
        end
      end
      FN_UDATA_WR:
        if (a[23]) uni[ui].extra = wd[3:0];
        else begin
          uni[ui].ppn = wd & 32'h1FFFFC00;
          uni[ui].flags = wd[8:0];
        end
      FN_IADDR_RD: r.rd = ins[ii].vpn | ins[ii].asid | (ins[ii].flags & 9'h100);
      FN_IDATA_RD: r.rd = ins[ii].ppn | ins[ii].flags;
      FN_UADDR_RD: r.rd = uni[ui].vpn | uni[ui].asid | (uni[ui].flags & 9'h100)
                          | (uni[ui].flags[FB_DIRTY] << 9);
      FN_UDATA_RD: r.rd = a[23] ? {28'd0, uni[ui].extra} : (uni[ui].ppn | uni[ui].flags);
      FN_INVAL: begin
        for (int i = 0; i < INSTR_N; i++) ins[i].flags[FB_VALID] = 0;
        for (int i = 0; i < N_UNI; i++) uni[i].flags[FB_VALID] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- result side ----------------
  bit calm = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int long_holds = 0;

  // receiver stalls: random bursts, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 0;
    end else if (hold_req) begin
      hold_req <= 0;
      long_holds <= long_holds + 1;
      hold_cnt <= 80;
      m_axis_tready <= 0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(0, 8);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // compare each result transaction
  always @(posedge clk) begin
    xlat_res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pa = m_axis_tdata[31:0];
      got.rd = m_axis_tdata[63:32];
      got.st = m_axis_tuser[3:0];
      sb.check_result(got);
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- request side ----------------
  int n_xlat = 0;
  int n_ok = 0;
  int n_sent = 0;
  logic [31:0] vpn_pool[8];

  task automatic pause_input(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(logic [3:0] fn, bit priv, logic [31:0] a, logic [31:0] wd,
                              logic [31:0] lo, logic [3:0] ab);
    xlat_res_t r;
    if (!calm && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 9));
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, ab, lo, wd, a};
    s_axis_tuser <= {priv, fn};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_request(fn, priv, a, wd, lo, ab);
    if (fn <= FN_FETCH) begin
      n_xlat++;
      if (r.st == STS_OK) n_ok++;
    end
    n_sent++;
    sb.note_request(r);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_XLAT_EN:  xlat_on = val[0];
      CFG_SV_MODE:  sv_mode = val[0];
      CFG_SQ_BLOCK: sq_block = val[0];
      CFG_ASID:     cur_asid = val;
      default:      repl_bound = val[5:0];
    endcase
  endtask

  task automatic set_mode(bit at, bit sv, bit sq, logic [7:0] asid, logic [5:0] bound);
    drain();
    write_reg(CFG_XLAT_EN, {7'd0, at});
    write_reg(CFG_SV_MODE, {7'd0, sv});
    write_reg(CFG_SQ_BLOCK, {7'd0, sq});
    write_reg(CFG_ASID, asid);
    write_reg(CFG_BOUNDARY, {2'd0, bound});
    cfg_wr_en <= 0;
  endtask

  // random request, mostly aimed at the small set of loaded pages
  task automatic random_request;
    int pick;
    logic [31:0] a, wd, lo;
    logic [3:0] fn;
    pick = $urandom_range(0, 99);
    a = $urandom();
    wd = $urandom();
    lo = $urandom();
    if (pick < 55) begin
      fn = 4'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 7) a = vpn_pool[$urandom_range(0, 7)] | $urandom_range(0, 32'hFFF);
    end else if (pick < 72) begin
      fn = FN_LOAD;
      wd = (vpn_pool[$urandom_range(0, 7)] & 32'hFFFFFC00)
           | ($urandom_range(0, 1) ? {24'd0, cur_asid} : $urandom_range(0, 255));
      lo[8] = $urandom_range(0, 4) != 0;
    end else if (pick < 84) begin
      fn = 4'($urandom_range(FN_IADDR_WR, FN_UDATA_WR));
      if (fn == FN_UADDR_WR && a[7] && $urandom_range(0, 1))
        wd = vpn_pool[$urandom_range(0, 7)] | cur_asid | (wd & 32'h300);
    end else if (pick < 96) begin
      fn = 4'($urandom_range(FN_IADDR_RD, FN_UDATA_RD));
    end else if (pick < 98) begin
      fn = FN_INVAL;
    end else begin
      fn = 4'($urandom_range(FN_SPARE, 15));
    end
    send_request(fn, 1'($urandom_range(0, 1)), a, wd, lo, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    repl_ctr = 0; plru = 0;
    xlat_on = 0; sv_mode = 0; sq_block = 0; cur_asid = 0; repl_bound = 0;
    for (int i = 0; i < N_UNI; i++) uni[i] = '{0, 0, 0, 0, 0};
    for (int i = 0; i < INSTR_N; i++) ins[i] = '{0, 0, 0, 0, 0};
    for (int i = 0; i < 8; i++)
      vpn_pool[i] = (i < 6) ? ($urandom() & 32'h7FFFF000) : (32'hC0000000 | ($urandom() & 32'h1FFFF000));
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: pass-through and address-error regions with translation off, and unused codes
    send_request(FN_READ, 0, 32'h00000000, 0, 0, 0);
    send_request(FN_READ, 1, 32'hFFFFFFFF, 0, 0, 0);
    send_request(FN_READ, 0, 32'h80000000, 0, 0, 0);
    send_request(FN_WRITE, 0, 32'hE0000000, 0, 0, 0);
    send_request(FN_WRITE, 0, 32'hE4000000, 0, 0, 0);
    send_request(FN_FETCH, 1, 32'hE0000000, 0, 0, 0);
    send_request(FN_FETCH, 0, 32'h90000000, 0, 0, 0);
    send_request(FN_FETCH, 1, 32'hA0000000, 0, 0, 0);
    send_request(FN_SPARE, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF);
    send_request(4'd15, 0, 32'h12345678, 0, 0, 0);

    // directed: entries, arrays, associative write, lookups
    set_mode(1, 0, 1, 8'hFF, 6'd0);
    send_request(FN_LOAD, 0, 0, 32'h12345FFF, 32'hFFFFFFFF, 4'hF);
    send_request(FN_LOAD, 0, 0, 32'h12345000, 32'h1FFFFD7E, 4'h5);
    send_request(FN_WRITE, 0, 32'h123457FF, 0, 0, 0);
    send_request(FN_READ, 1, 32'h12345001, 0, 0, 0);
    send_request(FN_FETCH, 0, 32'h12345002, 0, 0, 0);
    send_request(FN_FETCH, 1, 32'hC0000000, 0, 0, 0);
    send_request(FN_UADDR_WR, 0, 32'h00000080, 32'h123453FF, 0, 0);
    send_request(FN_UADDR_WR, 0, 32'hFFFFFF7F, 32'hFFFFFFFF, 0, 0);
    send_request(FN_UDATA_WR, 0, 32'h00803F00, 32'hFFFFFFFF, 0, 0);
    send_request(FN_UDATA_WR, 0, 32'h00003F00, 32'hFFFFFFFF, 0, 0);
    send_request(FN_IADDR_WR, 0, 32'h00000180, 32'hFFFFFFFF, 0, 0);
    send_request(FN_IDATA_WR, 0, 32'h00000180, 32'hFFFFFFFF, 0, 0);
    send_request(FN_IADDR_RD, 0, 32'h00000180, 0, 0, 0);
    send_request(FN_IDATA_RD, 0, 32'h00000180, 0, 0, 0);
    send_request(FN_UADDR_RD, 0, 32'h00003F00, 0, 0, 0);
    send_request(FN_UDATA_RD, 0, 32'h00803F00, 0, 0, 0);
    send_request(FN_INVAL, 0, 0, 0, 0, 0);

    // random phases under varied settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_mode(1, 0, 0, 8'h00, 6'd0);
        1: set_mode(1, 1, 1, 8'hFF, 6'd63);
        2: set_mode(1, 0, 1, 8'h5A, 6'd1);
        3: set_mode(0, 1, 0, 8'h00, 6'd0);
        4: set_mode(1, 1, 0, 8'h3C, 6'd17);
        default: set_mode(1, 0, 0, 8'hFF, 6'd5);
      endcase
      calm = (ph == 5);
      for (int k = 0; k < 165; k++) begin
        if (ph == 1 && k == 40) hold_req <= 1;
        random_request();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    $display("%0d requests, %0d translations (%0d ok), %0d results checked",
             n_sent, n_xlat, n_ok, sb.checked);
    $display("six register settings, %0d long output holds, %0d errors", long_holds, sb.errors);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
